// ----- rtl/rotation_matrix_to_quaternion_defines.svh -----
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RMQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rmq_pkg.sv -----
// shared codes and reciprocal square root seed table
`default_nettype none
package rmq_pkg;

  localparam logic [1:0] CASE_TRACE = 2'd0;
  localparam logic [1:0] CASE_X     = 2'd1;
  localparam logic [1:0] CASE_Y     = 2'd2;
  localparam logic [1:0] CASE_Z     = 2'd3;

  localparam int MQ_W  = 30;  // mantissa, unsigned q2.28
  localparam int Y_W   = 29;  // rsqrt estimate
  localparam int W_W   = 32;  // newton scratch
  localparam int SH_W  = 7;   // output shift amount

  localparam logic [15:0] SEED_TAB [32] = '{
    16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,
    16'd63580, 16'd60140, 16'd57205, 16'd54661, 16'd52429, 16'd50449, 16'd48679, 16'd47083,
    16'd45634, 16'd44310, 16'd43096, 16'd41977, 16'd40940, 16'd39977, 16'd39078, 16'd38237,
    16'd37449, 16'd36708, 16'd36008, 16'd35348, 16'd34722, 16'd34129, 16'd33564, 16'd33027
  };

endpackage
`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// rotation matrix to quaternion conversion, shepperd case selection, pipelined
//
// in_tdata carries one 3x3 matrix per beat, nine signed q1.14 elements.
// out_tdata carries the quaternion (qw, qx, qy, qz), saturated q1.14, and
// out_tuser the case taken (trace, x major, y major, z major).
// the pipeline has 6 + 3*RSQRT_STEPS register stages (12 at the defaults):
// case select, leading-one search, mantissa shift, seed lookup, three
// multiply stages per newton step of the reciprocal square root, then the
// four output products and the rounding/saturation stage.
// throughput is one matrix per cycle unless out_tready stalls; each stage
// has its own valid bit and moves whenever the stage after it is empty or
// moving, so bubbles collapse. when the receiver holds out_tready low the
// result stays on out_tdata and the stages behind it keep filling;
// in_tready drops only when every stage holds a beat.
// a synchronous active-low reset empties the pipeline; data is not cleared.
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH  = 16,
  parameter int FRAC_BITS   = 14,
  parameter int RSQRT_STEPS = 2
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // e00, e01, e02, e10, e11, e12, e20, e21, e22
  input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0]     in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // qw, qx, qy, qz
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]          out_tdata,
  // case_taken
  output logic [1:0]                                 out_tuser
);

  localparam int DW   = DATA_WIDTH;
  localparam int TW   = DW + 3;
  localparam int UW   = TW - 1;
  localparam int QW   = $clog2(TW + 1);
  localparam int NN   = 1 + 3 * RSQRT_STEPS;
  localparam int O1   = 3 + NN;
  localparam int NS   = O1 + 2;
  localparam int PW   = TW + rmq_pkg::Y_W;
  localparam int OTW  = ((4*DATA_WIDTH+7)/8)*8;
  localparam logic [rmq_pkg::W_W-1:0] THREE = (rmq_pkg::W_W)'(3) << 28;
  localparam logic [rmq_pkg::Y_W-1:0] YMAX  = {rmq_pkg::Y_W{1'b1}};
  localparam logic [PW:0] MAXPOS = (PW+1)'(1) << (DW - 1);

  typedef struct packed {
    logic [1:0]                  cs;
    logic [rmq_pkg::SH_W-1:0]    osh;
    logic [3:0][TW-1:0]          d;
    logic [rmq_pkg::MQ_W-1:0]    mq;
    logic [rmq_pkg::Y_W-1:0]     y;
    logic [rmq_pkg::W_W-1:0]     w;
  } nt_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_tready;
    for (int j = NS - 1; j >= 0; j--) begin
      en[j] = !v_r[j] || en[j+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];
  assign v_in       = {v_r[NS-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int j = 0; j < NS; j++) begin
        if (en[j]) begin
          v_r[j] <= v_in[j];
        end
      end
    end
  end

  // stage 0: case select, t and the three sums/differences
  logic signed [TW-1:0] m [9];
  logic signed [TW-1:0] tr, one_c;
  logic [1:0]           cs_nxt;
  logic signed [TW-1:0] t_nxt;
  logic [3:0][TW-1:0]   d_nxt;
  logic [1:0]           cs0_r;
  logic signed [TW-1:0] t0_r;
  logic [3:0][TW-1:0]   d0_r;

  always_comb begin
    d_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      m[i] = {{3{in_tdata[i*DW+DW-1]}}, in_tdata[i*DW +: DW]};
    end
    one_c = TW'(1) << FRAC_BITS;
    tr    = m[0] + m[4] + m[8];
    if (tr > 0) begin
      cs_nxt   = rmq_pkg::CASE_TRACE;
      t_nxt    = tr + one_c;
      d_nxt[1] = m[7] - m[5];
      d_nxt[2] = m[2] - m[6];
      d_nxt[3] = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      cs_nxt   = rmq_pkg::CASE_X;
      t_nxt    = m[0] - m[4] - m[8] + one_c;
      d_nxt[0] = m[7] - m[5];
      d_nxt[2] = m[1] + m[3];
      d_nxt[3] = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      cs_nxt   = rmq_pkg::CASE_Y;
      t_nxt    = m[4] - m[0] - m[8] + one_c;
      d_nxt[0] = m[2] - m[6];
      d_nxt[1] = m[3] + m[1];
      d_nxt[3] = m[7] + m[5];
    end else begin
      cs_nxt   = rmq_pkg::CASE_Z;
      t_nxt    = m[8] - m[0] - m[4] + one_c;
      d_nxt[0] = m[3] - m[1];
      d_nxt[1] = m[2] + m[6];
      d_nxt[2] = m[5] + m[7];
    end
    d_nxt[cs_nxt] = t_nxt;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cs0_r <= cs_nxt;
      t0_r  <= t_nxt;
      d0_r  <= d_nxt;
    end
  end

  // stage 1: clamp t, leading one, exponent
  logic [UW-1:0]            t1_nxt;
  logic [3:0][TW-1:0]       d1_nxt;
  int                       p_i, q_i;
  logic [QW-1:0]            qp1_nxt;
  logic [rmq_pkg::SH_W-1:0] osh_nxt;
  logic [1:0]               cs1_r;
  logic [UW-1:0]            t1_r;
  logic [3:0][TW-1:0]       d1_r;
  logic [QW-1:0]            qp1_r;
  logic [rmq_pkg::SH_W-1:0] osh1_r;

  always_comb begin
    d1_nxt = d0_r;
    if (t0_r <= 0) begin
      t1_nxt        = UW'(1);
      d1_nxt[cs0_r] = TW'(1);
    end else begin
      t1_nxt = t0_r[UW-1:0];
    end
    p_i = 0;
    for (int i = 0; i < UW; i++) begin
      if (t1_nxt[i]) begin
        p_i = i;
      end
    end
    q_i     = ((p_i - FRAC_BITS) % 2 != 0) ? p_i - 1 : p_i;
    qp1_nxt = QW'(q_i + 1);
    osh_nxt = (rmq_pkg::SH_W)'((58 + q_i - FRAC_BITS) >>> 1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cs1_r  <= cs0_r;
      t1_r   <= t1_nxt;
      d1_r   <= d1_nxt;
      qp1_r  <= qp1_nxt;
      osh1_r <= osh_nxt;
    end
  end

  // stage 2: mantissa into [1,4) as q2.28
  logic [UW+28:0]             xs;
  logic [rmq_pkg::MQ_W-1:0]   mq_nxt;
  logic [1:0]                 cs2_r;
  logic [rmq_pkg::SH_W-1:0]   osh2_r;
  logic [3:0][TW-1:0]         d2_r;
  logic [rmq_pkg::MQ_W-1:0]   mq2_r;

  always_comb begin
    xs     = {t1_r, 29'd0} >> qp1_r;
    mq_nxt = xs[rmq_pkg::MQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cs2_r  <= cs1_r;
      osh2_r <= osh1_r;
      d2_r   <= d1_r;
      mq2_r  <= mq_nxt;
    end
  end

  // seed lookup and newton steps, three stages per step
  nt_t nt_r [NN];

  genvar g;
  for (g = 0; g < NN; g++) begin : g_nt
    nt_t                           nt_nxt;
    logic [2*rmq_pkg::MQ_W-1:0]    prod;
    logic [rmq_pkg::W_W-1:0]       f;
    if (g == 0) begin : g_seed
      always_comb begin
        prod       = '0;
        f          = '0;
        nt_nxt.cs  = cs2_r;
        nt_nxt.osh = osh2_r;
        nt_nxt.d   = d2_r;
        nt_nxt.mq  = mq2_r;
        nt_nxt.y   = (rmq_pkg::Y_W)'({rmq_pkg::SEED_TAB[mq2_r[29:25]], 12'd0});
        nt_nxt.w   = '0;
      end
    end else if ((g - 1) % 3 == 0) begin : g_sq
      // y2 = y*y >> 28
      always_comb begin
        f      = '0;
        nt_nxt = nt_r[g-1];
        prod   = (2*rmq_pkg::MQ_W)'(nt_r[g-1].y) * (2*rmq_pkg::MQ_W)'(nt_r[g-1].y);
        nt_nxt.w = prod[28 +: rmq_pkg::W_W];
      end
    end else if ((g - 1) % 3 == 1) begin : g_h
      // h = mq*y2 >> 28
      always_comb begin
        f      = '0;
        nt_nxt = nt_r[g-1];
        prod   = (2*rmq_pkg::MQ_W)'(nt_r[g-1].mq)
               * (2*rmq_pkg::MQ_W)'(nt_r[g-1].w[rmq_pkg::MQ_W-1:0]);
        nt_nxt.w = prod[28 +: rmq_pkg::W_W];
      end
    end else begin : g_upd
      // y = y*(3 - h) >> 29, clamped
      always_comb begin
        nt_nxt = nt_r[g-1];
        f      = (nt_r[g-1].w >= THREE) ? '0 : THREE - nt_r[g-1].w;
        prod   = (2*rmq_pkg::MQ_W)'(nt_r[g-1].y) * (2*rmq_pkg::MQ_W)'(f[rmq_pkg::MQ_W-1:0]);
        nt_nxt.y = (prod[2*rmq_pkg::MQ_W-1:29] > (2*rmq_pkg::MQ_W-29)'(YMAX))
                 ? YMAX : prod[29 +: rmq_pkg::Y_W];
      end
    end
    always_ff @(posedge clk) begin
      if (en[3+g]) begin
        nt_r[g] <= nt_nxt;
      end
    end
  end

  // output stage 1: magnitudes times y
  logic [3:0][PW-1:0]        mul_nxt;
  logic [3:0]                neg_nxt;
  logic [TW-1:0]             mag;
  logic [3:0][PW-1:0]        mul_r;
  logic [3:0]                neg_r;
  logic [1:0]                cso_r;
  logic [rmq_pkg::SH_W-1:0]  osho_r;

  always_comb begin
    mag = '0;
    for (int i = 0; i < 4; i++) begin
      neg_nxt[i] = nt_r[NN-1].d[i][TW-1];
      mag        = neg_nxt[i] ? TW'(0) - nt_r[NN-1].d[i] : nt_r[NN-1].d[i];
      mul_nxt[i] = PW'(mag) * PW'(nt_r[NN-1].y);
    end
  end

  always_ff @(posedge clk) begin
    if (en[O1]) begin
      mul_r  <= mul_nxt;
      neg_r  <= neg_nxt;
      cso_r  <= nt_r[NN-1].cs;
      osho_r <= nt_r[NN-1].osh;
    end
  end

  // output stage 2: round half away from zero, saturate
  logic [3:0][DW-1:0] q_nxt;
  logic [PW:0]        rnd, r;
  logic [OTW-1:0]     tdata_r;
  logic [1:0]         tuser_r;

  always_comb begin
    rnd = '0;
    r   = '0;
    for (int i = 0; i < 4; i++) begin
      rnd = {1'b0, mul_r[i]} + ((PW+1)'(1) << (osho_r - (rmq_pkg::SH_W)'(1)));
      r   = rnd >> osho_r;
      if (neg_r[i]) begin
        if (r > MAXPOS) begin
          r = MAXPOS;
        end
        q_nxt[i] = DW'((PW+1)'(0) - r);
      end else begin
        if (r > MAXPOS - (PW+1)'(1)) begin
          r = MAXPOS - (PW+1)'(1);
        end
        q_nxt[i] = r[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      tdata_r <= OTW'(q_nxt);
      tuser_r <= cso_r;
    end
  end

  assign out_tdata = tdata_r;
  assign out_tuser = tuser_r;

  `RMQ_ASSERT_NOW(a_t_positive, v_r[1], t1_r != '0, "clamped t is zero")
  `RMQ_ASSERT_NOW(a_mq_range, v_r[2], mq2_r[29:28] != 2'b00, "mantissa below one")
  `RMQ_ASSERT_NEXT(a_seed_nonzero, v_r[2] && en[3], nt_r[0].y != '0, "seed is zero")

endmodule
`default_nettype wire
